@@ hdl/mdb_pkg.sv @@
// Package for the Morse digit beacon: sequencer phase type and fixed constants.
// Has no dependencies; used by morse_digit_beacon_core.
package mdb_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_PULSE = 3'd2,
    PH_PGAP  = 3'd3,
    PH_DGAP  = 3'd4,
    PH_NGAP  = 3'd5
  } phase_t;

  localparam logic [15:0] UNIT_MS_RESET  = 16'd200;
  localparam logic [7:0]  MAX_PERCENT    = 8'd100;
  localparam logic [2:0]  DIGIT_PULSES   = 3'd5;
  localparam logic [7:0]  TENS_RECIP     = 8'd205;
  localparam logic [3:0]  DASH_OFFSET    = 4'd5;

endpackage

@@ hdl/morse_digit_beacon_core.sv @@
// Morse digit beacon: blinks a charge percentage as Morse digits on an LED.
// Depends on mdb_pkg for the phase type and constants.
// Path: the input register, then the result register. Throughput: one word
// per cycle while out_stall does not hold the result; the input register
// feeds one pass of sequencer logic straight into the result register.
// Reset (rst, synchronous) empties both registers, sets the unit to 200 ms
// and leaves the sequencer idle with its LED level off; led_on is not reset.
module morse_digit_beacon_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        charging_active,
  input  logic [7:0]  soc_percent,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        led_on,
  output logic        busy_res
);
  import mdb_pkg::*;

  logic [15:0] unit_ms;

  logic        s1_valid;
  logic        s1_charging;
  logic [7:0]  s1_soc;
  logic [31:0] s1_now;
  logic        advance;

  phase_t      phase, phase_next;
  logic [31:0] mark_time, mark_time_next;
  logic [6:0]  shown_value, shown_value_next;
  logic        value_valid, value_valid_next;
  logic [3:0]  digit_store [3];
  logic [3:0]  digit_store_next [3];
  logic [1:0]  digit_count, digit_count_next;
  logic [1:0]  digit_pos, digit_pos_next;
  logic [2:0]  pulse_pos, pulse_pos_next;
  logic        led_level, led_level_next;

  logic [6:0]  soc7;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones_full;
  logic        restart;
  logic [31:0] elapsed;
  logic [17:0] unit_x3;
  logic [18:0] unit_x7;
  logic [3:0]  cur_digit;
  logic        pulse_dot;
  logic [2:0]  pulse_inc;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ms <= UNIT_MS_RESET;
    end else if (cfg_wr_en) begin
      unit_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_charging <= charging_active;
      s1_soc      <= soc_percent;
      s1_now      <= now_ms;
    end
  end

  // Decimal split of a percentage below 100; tens by reciprocal multiply.
  assign soc7      = s1_soc[6:0];
  assign tens_prod = {8'd0, soc7} * {7'd0, TENS_RECIP};
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones_full = soc7 - tens_x10;

  assign restart = !value_valid || (soc7 != shown_value) || (phase == PH_IDLE);
  assign elapsed = restart ? 32'd0 : (s1_now - mark_time);
  assign unit_x3 = {2'b00, unit_ms} + {1'b0, unit_ms, 1'b0};
  assign unit_x7 = {unit_ms, 3'b000} - {3'b000, unit_ms};

  always_comb begin
    case (digit_pos)
      2'd0:    cur_digit = digit_store[0];
      2'd1:    cur_digit = digit_store[1];
      2'd2:    cur_digit = digit_store[2];
      default: cur_digit = 4'd0;
    endcase
  end

  assign pulse_dot = (cur_digit <= DASH_OFFSET) ? ({1'b0, pulse_pos} < cur_digit)
                                                : ({1'b0, pulse_pos} >= cur_digit - DASH_OFFSET);
  assign pulse_inc = pulse_pos + 3'd1;

  always_comb begin
    phase_next          = phase;
    mark_time_next      = mark_time;
    shown_value_next    = shown_value;
    value_valid_next    = value_valid;
    digit_store_next[0] = digit_store[0];
    digit_store_next[1] = digit_store[1];
    digit_store_next[2] = digit_store[2];
    digit_count_next    = digit_count;
    digit_pos_next      = digit_pos;
    pulse_pos_next      = pulse_pos;
    led_level_next      = led_level;
    if (!s1_charging) begin
      led_level_next   = 1'b0;
      phase_next       = PH_IDLE;
      value_valid_next = 1'b0;
    end else if (s1_soc <= MAX_PERCENT) begin
      if (restart) begin
        shown_value_next = soc7;
        value_valid_next = 1'b1;
        digit_pos_next   = 2'd0;
        phase_next       = PH_START;
        mark_time_next   = s1_now;
        if (s1_soc == MAX_PERCENT) begin
          digit_store_next[0] = 4'd1;
          digit_store_next[1] = 4'd0;
          digit_store_next[2] = 4'd0;
          digit_count_next    = 2'd3;
        end else if (soc7 >= 7'd10) begin
          digit_store_next[0] = tens;
          digit_store_next[1] = ones_full[3:0];
          digit_count_next    = 2'd2;
        end else begin
          digit_store_next[0] = soc7[3:0];
          digit_count_next    = 2'd1;
        end
      end
      case (phase_next)
        PH_START: begin
          if (digit_pos_next >= digit_count_next) begin
            phase_next = PH_NGAP;
          end else begin
            pulse_pos_next = 3'd0;
            phase_next     = PH_PULSE;
            mark_time_next = s1_now;
          end
        end
        PH_PULSE: begin
          led_level_next = 1'b1;
          if (elapsed >= (pulse_dot ? {16'd0, unit_ms} : {14'd0, unit_x3})) begin
            phase_next     = PH_PGAP;
            mark_time_next = s1_now;
          end
        end
        PH_PGAP: begin
          led_level_next = 1'b0;
          if (elapsed >= {16'd0, unit_ms}) begin
            pulse_pos_next = pulse_inc;
            phase_next     = (pulse_inc >= DIGIT_PULSES) ? PH_DGAP : PH_PULSE;
            mark_time_next = s1_now;
          end
        end
        PH_DGAP: begin
          led_level_next = 1'b0;
          if (elapsed >= {14'd0, unit_x3}) begin
            digit_pos_next = digit_pos + 2'd1;
            phase_next     = PH_START;
            mark_time_next = s1_now;
          end
        end
        PH_NGAP: begin
          led_level_next = 1'b0;
          if (elapsed >= {13'd0, unit_x7}) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      mark_time   <= 32'd0;
      shown_value <= 7'd0;
      value_valid <= 1'b0;
      digit_count <= 2'd0;
      digit_pos   <= 2'd0;
      pulse_pos   <= 3'd0;
      led_level   <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      mark_time   <= mark_time_next;
      shown_value <= shown_value_next;
      value_valid <= value_valid_next;
      digit_count <= digit_count_next;
      digit_pos   <= digit_pos_next;
      pulse_pos   <= pulse_pos_next;
      led_level   <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      digit_store[0] <= digit_store_next[0];
      digit_store[1] <= digit_store_next[1];
      digit_store[2] <= digit_store_next[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_on   <= led_level_next;
      busy_res <= (phase_next != PH_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_idle_led_off : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !led_level)
    else $error("LED is lit while the sequencer is idle");

  a_no_value_idle : assert property (@(posedge clk) disable iff (rst)
    !value_valid |-> (phase == PH_IDLE))
    else $error("Sequence is running without a stored percentage");

  a_digits_loaded : assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (digit_count != 2'd0))
    else $error("Sequence is running with no digits loaded");

  a_pulse_range : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PULSE) |-> (pulse_pos < DIGIT_PULSES))
    else $error("Pulse index ran past the end of a digit");

  a_result_loaded : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_stall) |=> out_valid)
    else $error("Pending word did not reach the result register");
`endif

endmodule
